/* hw/rtl/text_row_dot_stretch_renderer_top_assert.svh */
// Assertion macros shared by the character generator RTL.
`ifndef TEXT_ROW_DOT_STRETCH_RENDERER_TOP_ASSERT_SVH
`define TEXT_ROW_DOT_STRETCH_RENDERER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TRDSR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("character generator check failed");

// Consequent must hold in the cycle after the antecedent.
`define TRDSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("character generator check failed");

`endif

/* hw/rtl/trdsr_pkg.sv */
// Shared constants, types and helper functions of the character generator.
`default_nettype none

package trdsr_pkg;

  localparam int LINES_PER_CHAR = 10;
  localparam int FONT_ENTRIES   = 2048;
  localparam int CELL_DOTS      = 10;

  localparam int FONT_AW = $clog2(FONT_ENTRIES);
  localparam int LINE_W  = $clog2(LINES_PER_CHAR);
  localparam int CNT_W   = $clog2(CELL_DOTS);
  localparam int RAW_AW  = 11;
  localparam int WRAP_W  = RAW_AW + 2;
  localparam int BYTE_W  = 8;
  localparam int SCAN_W  = 8;
  localparam int CODE_W  = 7;
  localparam int MODE_W  = 2;

  // Input tdata layout, lowest bit first.
  localparam int ADDR_LSB   = 0;
  localparam int BYTE_LSB   = ADDR_LSB + RAW_AW;
  localparam int SCAN_LSB   = BYTE_LSB + BYTE_W;
  localparam int CODE_LSB   = SCAN_LSB + SCAN_W;
  localparam int MODE_LSB   = CODE_LSB + CODE_W;
  localparam int VIS_BIT    = MODE_LSB + MODE_W;
  localparam int ON_BIT     = VIS_BIT + 1;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  // Reciprocals for division by the line count and by the font size.
  localparam int LINE_SH    = 16;
  localparam int LINE_RECIP = (1 << LINE_SH) / LINES_PER_CHAR;
  localparam int FONT_SH    = 24;
  localparam int FONT_RECIP = (1 << FONT_SH) / FONT_ENTRIES;

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_RENDER = 1'b1
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL    = 2'd0,
    MODE_DH_BOTTOM = 2'd1,
    MODE_DH_TOP    = 2'd2,
    MODE_DW        = 2'd3
  } mode_t;

  // One fetched cell handed from the font stage to the dot shifter.
  typedef struct packed {
    logic              valid;
    logic              blank;
    logic              dbl;
    logic [BYTE_W-1:0] glyph;
  } cell_t;

  // Scanline modulo the character height: reciprocal estimate, one correction.
  function automatic logic [LINE_W-1:0] glyph_line(input logic [SCAN_W-1:0] scan);
    logic [SCAN_W+LINE_SH-1:0] prod;
    logic [SCAN_W-1:0]         quo;
    logic [SCAN_W-1:0]         rem;
    prod = (SCAN_W+LINE_SH)'(scan) * (SCAN_W+LINE_SH)'(LINE_RECIP);
    quo  = prod[SCAN_W+LINE_SH-1:LINE_SH];
    rem  = scan - SCAN_W'(quo * SCAN_W'(LINES_PER_CHAR));
    if (rem >= SCAN_W'(LINES_PER_CHAR)) begin
      rem = rem - SCAN_W'(LINES_PER_CHAR);
    end
    return rem[LINE_W-1:0];
  endfunction

  // Wraps a raw address into the font store.
  function automatic logic [FONT_AW-1:0] font_wrap(input logic [RAW_AW-1:0] addr);
    logic [RAW_AW+FONT_SH-1:0] prod;
    logic [WRAP_W-1:0]         quo;
    logic [WRAP_W-1:0]         rem;
    prod = (RAW_AW+FONT_SH)'(addr) * (RAW_AW+FONT_SH)'(FONT_RECIP);
    quo  = WRAP_W'(prod[RAW_AW+FONT_SH-1:FONT_SH]);
    rem  = WRAP_W'(addr) - WRAP_W'(quo * WRAP_W'(FONT_ENTRIES));
    if (rem >= WRAP_W'(FONT_ENTRIES)) begin
      rem = rem - WRAP_W'(FONT_ENTRIES);
    end
    return rem[FONT_AW-1:0];
  endfunction

  // Each dot is its own font bit ORed with the bit to its left; the
  // leftmost dot lands in the top bit and the final dot stays dark.
  function automatic logic [CELL_DOTS-1:0] stretch_dots(input logic [BYTE_W-1:0] glyph);
    logic [BYTE_W:0] dots;
    dots = {1'b0, glyph} | {glyph, 1'b0};
    return {dots, (CELL_DOTS-BYTE_W-1)'(0)};
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/trdsr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module trdsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/trdsr_fetch.sv */
// Input register, glyph line and address logic, font store and fetched cell stage.
`default_nettype none

module trdsr_fetch (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [trdsr_pkg::IN_DATA_W-1:0] in_data,
  input  wire logic                            in_user,
  input  wire logic                            take,
  output trdsr_pkg::cell_t                     fetched
);

  logic                              hold;
  trdsr_pkg::op_t                    hold_op;
  logic [trdsr_pkg::RAW_AW-1:0]      hold_faddr;
  logic [trdsr_pkg::BYTE_W-1:0]      hold_byte;
  logic [trdsr_pkg::SCAN_W-1:0]      hold_scan;
  logic [trdsr_pkg::CODE_W-1:0]      hold_code;
  trdsr_pkg::mode_t                  hold_mode;
  logic                              hold_blank;

  logic                              cell_valid;
  logic                              cell_blank;
  logic                              cell_dbl;
  logic [trdsr_pkg::BYTE_W-1:0]      glyph;

  logic                              cell_ready;
  logic                              advance;
  logic                              is_render;
  logic                              ram_we;
  logic                              ram_re;
  logic [trdsr_pkg::LINE_W-1:0]      base_line;
  logic [trdsr_pkg::LINE_W-1:0]      line;
  logic [trdsr_pkg::RAW_AW-1:0]      raw_addr;
  logic [trdsr_pkg::FONT_AW-1:0]     rd_addr;
  logic [trdsr_pkg::FONT_AW-1:0]     wr_addr;

  assign is_render  = hold_op == trdsr_pkg::OP_RENDER;
  assign cell_ready = !cell_valid || take;
  // A load finishes in the held cycle; a render waits for the cell stage.
  assign advance    = hold && (!is_render || cell_ready);
  assign in_ready   = !hold || advance;

  always_comb begin
    base_line = trdsr_pkg::glyph_line(hold_scan);
    unique case (hold_mode)
      trdsr_pkg::MODE_DH_BOTTOM: line = (base_line >> 1)
                                        + trdsr_pkg::LINE_W'(trdsr_pkg::LINES_PER_CHAR / 2);
      trdsr_pkg::MODE_DH_TOP:    line = base_line >> 1;
      trdsr_pkg::MODE_NORMAL:    line = base_line;
      trdsr_pkg::MODE_DW:        line = base_line;
      default:                   line = base_line;
    endcase
  end

  assign raw_addr = (trdsr_pkg::RAW_AW'(line) << trdsr_pkg::CODE_W)
                  | trdsr_pkg::RAW_AW'(hold_code);
  assign rd_addr  = trdsr_pkg::font_wrap(raw_addr);
  assign wr_addr  = trdsr_pkg::font_wrap(hold_faddr);
  assign ram_we   = hold && !is_render;
  assign ram_re   = hold && is_render && cell_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (in_ready) begin
      hold <= in_valid;
    end
    if (in_ready && in_valid) begin
      hold_op    <= trdsr_pkg::op_t'(in_user);
      hold_faddr <= in_data[trdsr_pkg::ADDR_LSB +: trdsr_pkg::RAW_AW];
      hold_byte  <= in_data[trdsr_pkg::BYTE_LSB +: trdsr_pkg::BYTE_W];
      hold_scan  <= in_data[trdsr_pkg::SCAN_LSB +: trdsr_pkg::SCAN_W];
      hold_code  <= in_data[trdsr_pkg::CODE_LSB +: trdsr_pkg::CODE_W];
      hold_mode  <= trdsr_pkg::mode_t'(in_data[trdsr_pkg::MODE_LSB +: trdsr_pkg::MODE_W]);
      hold_blank <= !in_data[trdsr_pkg::VIS_BIT] || !in_data[trdsr_pkg::ON_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
    end else if (cell_ready) begin
      cell_valid <= hold && is_render;
    end
    if (ram_re) begin
      cell_blank <= hold_blank;
      cell_dbl   <= hold_mode != trdsr_pkg::MODE_NORMAL;
    end
  end

  // Read data only moves on a read, so a stalled cell keeps its glyph.
  trdsr_ram #(
    .WIDTH (trdsr_pkg::BYTE_W),
    .DEPTH (trdsr_pkg::FONT_ENTRIES)
  ) u_font (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (hold_byte),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (glyph)
  );

  assign fetched.valid = cell_valid;
  assign fetched.blank = cell_blank;
  assign fetched.dbl   = cell_dbl;
  assign fetched.glyph = glyph;

endmodule

`default_nettype wire

/* hw/rtl/trdsr_dotser.sv */
// Dot shifter: turns one fetched cell into its sequence of output dots.
`default_nettype none

module trdsr_dotser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire trdsr_pkg::cell_t      fetched,
  output logic                       take,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       pixel_on,
  output logic                       last_pixel
);

  logic [trdsr_pkg::CELL_DOTS-1:0] pattern;
  logic [trdsr_pkg::CNT_W-1:0]     dot_cnt;
  logic                            phase;
  logic                            dbl;
  logic                            busy;
  logic                            fire;

  assign fire       = busy && out_ready;
  assign last_pixel = (dot_cnt == trdsr_pkg::CNT_W'(trdsr_pkg::CELL_DOTS - 1))
                    && (!dbl || phase);
  assign take       = fetched.valid && (!busy || (fire && last_pixel));
  assign out_valid  = busy;
  assign pixel_on   = pattern[trdsr_pkg::CELL_DOTS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      dot_cnt <= '0;
      phase   <= 1'b0;
      dbl     <= 1'b0;
    end else if (take) begin
      busy    <= 1'b1;
      dot_cnt <= '0;
      phase   <= 1'b0;
      // A blanked cell is always ten single dots.
      dbl     <= fetched.dbl && !fetched.blank;
    end else if (fire) begin
      if (last_pixel) begin
        busy <= 1'b0;
      end else if (dbl && !phase) begin
        phase <= 1'b1;
      end else begin
        phase   <= 1'b0;
        dot_cnt <= dot_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pattern <= fetched.blank ? '0 : trdsr_pkg::stretch_dots(fetched.glyph);
    end else if (fire && !last_pixel && (!dbl || phase)) begin
      pattern <= pattern << 1;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/text_row_dot_stretch_renderer_top.sv */
// Top level of the text-row character generator with dot stretching.
//
//   channel  | direction | contents
//   s_axis   | in        | tuser: operation; tdata: load and render fields
//   m_axis   | out       | tdata: pixel_on; tlast: last_pixel
//
// A render transfer yields 10 dots, or 20 when a shown cell has any double mode
// set; the dot shifter sends one dot per cycle while m_axis_tready is high.
// A load is written to the font store and yields no dots. The first dot of a
// cell passes the input register, the font RAM read and the pattern register.
// Reset clears all control state; the font store holds no reset value.
// While the output stalls, the fetched cell and the input register keep
// taking items until each is full.
`default_nettype none

module text_row_dot_stretch_renderer_top (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [10:0] font_address, [18:11] font_byte, [26:19] scanline,
  // [33:27] char_code, [35:34] height_mode, [36] row_visible, [37] display_on
  input  wire logic [trdsr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] operation
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [0] pixel_on
  output logic      [trdsr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                                  m_axis_tlast
);

  trdsr_pkg::cell_t fetched;
  logic             take;
  logic             pixel_on;

  trdsr_fetch u_fetch (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .in_user  (s_axis_tuser),
    .take     (take),
    .fetched  (fetched)
  );

  trdsr_dotser u_dotser (
    .clk        (clk),
    .rst        (rst),
    .fetched    (fetched),
    .take       (take),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .pixel_on   (pixel_on),
    .last_pixel (m_axis_tlast)
  );

  assign m_axis_tdata = {(trdsr_pkg::OUT_DATA_W-1)'(0), pixel_on};

`include "text_row_dot_stretch_renderer_top_assert.svh"

  // The final dot of every cell is dark.
  `TRDSR_ASSERT_NOW(a_last_dark, m_axis_tvalid && m_axis_tlast, !m_axis_tdata[0])
  // With no cell waiting, the output goes idle after the closing transfer.
  `TRDSR_ASSERT_NEXT(a_idle_after_cell,
    m_axis_tvalid && m_axis_tready && m_axis_tlast && !fetched.valid, !m_axis_tvalid)
  // A fetched cell that is not taken keeps its glyph and mode.
  `TRDSR_ASSERT_NEXT(a_cell_holds, fetched.valid && !take,
    fetched.valid && $stable(fetched.glyph) && $stable(fetched.dbl) && $stable(fetched.blank))

endmodule

`default_nettype wire

/* tb/sv/tb_text_row_dot_stretch_renderer_top.sv */
// Self-checking testbench of the character generator, with directed and random cells.
module tb_text_row_dot_stretch_renderer_top;

  localparam int GAP_MAX   = 12;
  localparam int HOLD_LEN  = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int RAND_ITEMS = 45;

  typedef struct packed {
    trdsr_pkg::op_t   op;
    logic [10:0]      addr;
    logic [7:0]       fbyte;
    logic [7:0]       scan;
    logic [6:0]       code;
    trdsr_pkg::mode_t mode;
    logic             vis;
    logic             on;
  } cell_req_t;

  typedef struct packed {
    logic on;
    logic last;
  } dot_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [trdsr_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                             s_axis_tuser = 1'b0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [trdsr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                             m_axis_tlast;

  // Copy of the font store and a record of which entries hold data.
  logic [7:0] font_copy [0:trdsr_pkg::FONT_ENTRIES-1];
  bit         font_loaded [0:trdsr_pkg::FONT_ENTRIES-1];
  dot_t       pending_dots [$];

  // Directed stimulus table.
  cell_req_t   dir_req [$];
  int          dir_n [$];
  logic [19:0] dir_dots [$];

  int   mismatches = 0;
  int   idle_cycles = 0;
  bit   tx_burst = 1'b0;
  bit   rx_burst = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;
  dot_t head_dot;

  text_row_dot_stretch_renderer_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  function automatic logic [10:0] glyph_addr(input cell_req_t r);
    int line;
    line = int'(r.scan) % trdsr_pkg::LINES_PER_CHAR;
    case (r.mode)
      trdsr_pkg::MODE_DH_BOTTOM: line = line / 2 + trdsr_pkg::LINES_PER_CHAR / 2;
      trdsr_pkg::MODE_DH_TOP:    line = line / 2;
      default:                   line = line;
    endcase
    return 11'((line * 128 + int'(r.code)) % trdsr_pkg::FONT_ENTRIES);
  endfunction

  // Updates the font copy on a load and queues the dots that a render gives.
  function automatic void predict_cell(input cell_req_t r);
    logic [7:0] glyph;
    logic [8:0] dots;
    int         reps;
    dot_t       d;
    if (r.op == trdsr_pkg::OP_LOAD) begin
      font_copy[int'(r.addr) % trdsr_pkg::FONT_ENTRIES] = r.fbyte;
      font_loaded[int'(r.addr) % trdsr_pkg::FONT_ENTRIES] = 1'b1;
      return;
    end
    if (!r.on || !r.vis) begin
      for (int k = 0; k < trdsr_pkg::CELL_DOTS; k++) begin
        d.on = 1'b0;
        d.last = (k == trdsr_pkg::CELL_DOTS - 1);
        pending_dots.push_back(d);
      end
      return;
    end
    glyph = font_copy[glyph_addr(r)];
    dots = {1'b0, glyph} | {glyph, 1'b0};
    reps = (r.mode != trdsr_pkg::MODE_NORMAL) ? 2 : 1;
    for (int k = 0; k < trdsr_pkg::CELL_DOTS; k++) begin
      for (int n = 0; n < reps; n++) begin
        d.on = (k < 9) ? dots[8-k] : 1'b0;
        d.last = (k == trdsr_pkg::CELL_DOTS - 1) && (n == reps - 1);
        pending_dots.push_back(d);
      end
    end
  endfunction

  task automatic add_row(input trdsr_pkg::op_t op, input logic [10:0] addr,
                         input logic [7:0] fbyte, input logic [7:0] scan,
                         input logic [6:0] code, input trdsr_pkg::mode_t mode,
                         input logic vis, input logic on, input int n,
                         input logic [19:0] dots);
    cell_req_t r;
    r = '{op: op, addr: addr, fbyte: fbyte, scan: scan, code: code, mode: mode,
          vis: vis, on: on};
    dir_req.push_back(r);
    dir_n.push_back(n);
    dir_dots.push_back(dots);
  endtask

  // Offers one item after a random gap; a nonzero fixed_n gives the dots typed in by hand.
  task automatic send_cell(input cell_req_t r, input int fixed_n, input logic [19:0] fixed_dots);
    int   gap;
    dot_t d;
    gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {2'b00, r.on, r.vis, r.mode, r.code, r.scan, r.fbyte, r.addr};
    do @(posedge clk); while (!s_axis_tready);
    if (fixed_n > 0) begin
      for (int k = 0; k < fixed_n; k++) begin
        d.on = fixed_dots[k];
        d.last = (k == fixed_n - 1);
        pending_dots.push_back(d);
      end
    end else begin
      predict_cell(r);
    end
  endtask

  task automatic wait_drained;
    while (pending_dots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Output checker.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_dots.size() == 0) begin
        $display("%0t: unexpected dot: expected none, got on=%0b last=%0b",
                 $time, m_axis_tdata[0], m_axis_tlast);
        mismatches++;
      end else begin
        head_dot = pending_dots.pop_front();
        if (m_axis_tdata[0] !== head_dot.on || m_axis_tlast !== head_dot.last) begin
          $display("%0t: dot mismatch: expected on=%0b last=%0b, got on=%0b last=%0b",
                   $time, head_dot.on, head_dot.last, m_axis_tdata[0], m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: random stalls, bursts without stalls, and one long hold-off.
  initial begin : dot_sink
    int wait_n;
    int taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        hold_done = 1'b1;
      end
      wait_n = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (wait_n > 0) begin
        m_axis_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      taken++;
      if (taken % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
    end
  end

  initial begin : stimulus
    cell_req_t r;
    cell_req_t pre;
    // Loads carry junk in the render fields and renders junk in the load fields.
    add_row(trdsr_pkg::OP_LOAD,   11'd0,    8'hFF, 8'hFF, 7'h7F, trdsr_pkg::MODE_DW,
            1'b1, 1'b1, 0, 20'h0);
    add_row(trdsr_pkg::OP_LOAD,   11'd2047, 8'h00, 8'h00, 7'h00, trdsr_pkg::MODE_NORMAL,
            1'b0, 1'b0, 0, 20'h0);
    add_row(trdsr_pkg::OP_LOAD,   11'd1279, 8'h80, 8'h00, 7'h00, trdsr_pkg::MODE_NORMAL,
            1'b0, 1'b0, 0, 20'h0);
    add_row(trdsr_pkg::OP_LOAD,   11'd127,  8'h01, 8'h00, 7'h00, trdsr_pkg::MODE_NORMAL,
            1'b0, 1'b0, 0, 20'h0);
    add_row(trdsr_pkg::OP_LOAD,   11'd767,  8'hA5, 8'h00, 7'h00, trdsr_pkg::MODE_NORMAL,
            1'b0, 1'b0, 0, 20'h0);
    add_row(trdsr_pkg::OP_LOAD,   11'd639,  8'h5A, 8'h00, 7'h00, trdsr_pkg::MODE_NORMAL,
            1'b0, 1'b0, 0, 20'h0);
    add_row(trdsr_pkg::OP_LOAD,   11'd640,  8'h3C, 8'h00, 7'h00, trdsr_pkg::MODE_NORMAL,
            1'b0, 1'b0, 0, 20'h0);
    // A full glyph line: nine lit dots and a dark one, doubled in double width.
    add_row(trdsr_pkg::OP_RENDER, 11'd2047, 8'hFF, 8'd0,   7'd0,   trdsr_pkg::MODE_NORMAL,
            1'b1, 1'b1, 10, 20'h001FF);
    add_row(trdsr_pkg::OP_RENDER, 11'd0,    8'h00, 8'd0,   7'd0,   trdsr_pkg::MODE_DW,
            1'b1, 1'b1, 20, 20'h3FFFF);
    // Blanked cells are ten dark dots in any height mode.
    add_row(trdsr_pkg::OP_RENDER, 11'd0,    8'h00, 8'd0,   7'd0,   trdsr_pkg::MODE_NORMAL,
            1'b1, 1'b0, 10, 20'h0);
    add_row(trdsr_pkg::OP_RENDER, 11'd0,    8'h00, 8'd0,   7'd0,   trdsr_pkg::MODE_NORMAL,
            1'b0, 1'b1, 10, 20'h0);
    add_row(trdsr_pkg::OP_RENDER, 11'd0,    8'h00, 8'd0,   7'd0,   trdsr_pkg::MODE_DW,
            1'b0, 1'b0, 10, 20'h0);
    add_row(trdsr_pkg::OP_RENDER, 11'd0,    8'h00, 8'd0,   7'd0,   trdsr_pkg::MODE_DH_TOP,
            1'b0, 1'b1, 10, 20'h0);
    add_row(trdsr_pkg::OP_RENDER, 11'd0,    8'h00, 8'd255, 7'd127, trdsr_pkg::MODE_NORMAL,
            1'b1, 1'b1, 0, 20'h0);
    add_row(trdsr_pkg::OP_RENDER, 11'd0,    8'h00, 8'd9,   7'd127, trdsr_pkg::MODE_NORMAL,
            1'b1, 1'b1, 0, 20'h0);
    add_row(trdsr_pkg::OP_RENDER, 11'd0,    8'h00, 8'd9,   7'd127, trdsr_pkg::MODE_DH_BOTTOM,
            1'b1, 1'b1, 0, 20'h0);
    add_row(trdsr_pkg::OP_RENDER, 11'd0,    8'h00, 8'd9,   7'd127, trdsr_pkg::MODE_DH_TOP,
            1'b1, 1'b1, 0, 20'h0);
    add_row(trdsr_pkg::OP_RENDER, 11'd0,    8'h00, 8'd0,   7'd0,   trdsr_pkg::MODE_DH_BOTTOM,
            1'b1, 1'b1, 0, 20'h0);
    add_row(trdsr_pkg::OP_RENDER, 11'd0,    8'h00, 8'd0,   7'd0,   trdsr_pkg::MODE_DH_TOP,
            1'b1, 1'b1, 0, 20'h0);
    add_row(trdsr_pkg::OP_RENDER, 11'd0,    8'h00, 8'd250, 7'd127, trdsr_pkg::MODE_DW,
            1'b1, 1'b1, 0, 20'h0);
    add_row(trdsr_pkg::OP_RENDER, 11'd0,    8'h00, 8'd10,  7'd127, trdsr_pkg::MODE_NORMAL,
            1'b1, 1'b1, 0, 20'h0);
    add_row(trdsr_pkg::OP_LOAD,   11'd0,    8'h00, 8'h00,  7'h00,  trdsr_pkg::MODE_NORMAL,
            1'b0, 1'b0, 0, 20'h0);
    add_row(trdsr_pkg::OP_RENDER, 11'd0,    8'h00, 8'd0,   7'd0,   trdsr_pkg::MODE_NORMAL,
            1'b1, 1'b1, 10, 20'h0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < dir_req.size(); i++) begin
      send_cell(dir_req[i], dir_n[i], dir_dots[i]);
    end
    s_axis_tvalid <= 1'b0;
    wait_drained();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 25 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      if (i == 15) begin
        // Long output stall while items keep coming, so the input backs up.
        hold_req = 1'b1;
        tx_burst = 1'b1;
      end
      if (i == 30) begin
        s_axis_tvalid <= 1'b0;
        wait_drained();
      end
      r.op    = ($urandom_range(0, 9) < 2) ? trdsr_pkg::OP_LOAD : trdsr_pkg::OP_RENDER;
      r.addr  = 11'($urandom_range(0, 2047));
      r.fbyte = 8'($urandom_range(0, 255));
      r.scan  = 8'($urandom_range(0, 255));
      r.code  = 7'($urandom_range(0, 127));
      r.mode  = trdsr_pkg::mode_t'($urandom_range(0, 3));
      r.vis   = ($urandom_range(0, 7) != 0);
      r.on    = ($urandom_range(0, 7) != 0);
      if (r.op == trdsr_pkg::OP_RENDER && !font_loaded[glyph_addr(r)]) begin
        // Fill the glyph entry first so that no render reads an empty entry.
        pre = r;
        pre.op = trdsr_pkg::OP_LOAD;
        pre.addr = glyph_addr(r);
        pre.fbyte = 8'($urandom_range(0, 255));
        send_cell(pre, 0, 20'h0);
      end
      send_cell(r, 0, 20'h0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_dots.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
